// ----- hdl/cbq_pkg.sv -----
// Shared types, constants and helpers for the cascaded biquad filter.
package cbq_pkg;

    // Widths of the arithmetic
    localparam int unsigned COEF_W    = 18;  // Q2.16 coefficient
    localparam int unsigned DLY_W     = 32;  // Q8.24 delay / section data
    localparam int unsigned ACC_W     = 54;  // exact Q.40 sum of products
    localparam int unsigned RND_W     = ACC_W - 16;
    localparam int unsigned GAIN_W    = 16;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned COEFS_PER = 5;

    // Coefficient slots
    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd60000;

    // Product order within one section
    localparam logic [2:0] PROD_A1 = 3'd0;
    localparam logic [2:0] PROD_A2 = 3'd1;
    localparam logic [2:0] PROD_B0 = 3'd2;
    localparam logic [2:0] PROD_B1 = 3'd3;
    localparam logic [2:0] PROD_B2 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC_START,
        ST_FETCH,
        ST_LOAD,
        ST_MUL,
        ST_ROUND,
        ST_GAIN_MUL,
        ST_OUT
    } state_t;

    // Coefficient slot used by each product step
    function automatic logic [2:0] slot_of(input logic [2:0] prod);
        logic [2:0] s;
        case (prod)
            PROD_A1: s = SLOT_A1;
            PROD_A2: s = SLOT_A2;
            PROD_B0: s = SLOT_B0;
            PROD_B1: s = SLOT_B1;
            PROD_B2: s = SLOT_B2;
            default: s = SLOT_B0;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/cascaded_biquad_iir_filter.sv -----
// Top level: bit-serial cascade of direct-form-II biquad sections.
//
// Input stream (s_tvalid/s_tready): tuser is the item kind. Kind 0 filters
// one Q1.15 sample, kind 1 writes one Q2.16 coefficient into the store.
// Output stream (m_tvalid/m_tready): one beat per filtered sample, the
// saturated, gain-scaled sample in tdata and the clip flag in tuser.
// Config channel (cfg_valid/cfg_ready): writes the 16-bit output gain.
//
// Every product is formed by one shared shift-and-add unit, one multiplier
// bit per cycle. Each section forms its five products in turn, each after
// a fetch and a load state, with a round after the a2 and b2 products;
// the gain product follows the last section. Items are taken one at a
// time; s_tready is high only while the sequencer is idle.
// The result sits in an output register: a new item is accepted while it
// waits; if the next result is ready first, the sequencer holds until the
// receiver takes the earlier beat. Reset zeroes all delays, marks every
// coefficient as zero and sets the gain to 60000.
module cascaded_biquad_iir_filter #(
    parameter int SECTIONS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: sample_in[15:0], coef_section[18:16], coef_slot[21:19],
    //        coef_value[39:22]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,   // kind
    // tdata: sample_out[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tuser,   // clipped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = SECTIONS * cbq_pkg::COEFS_PER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int ACC_W = cbq_pkg::ACC_W;
    localparam int DLY_W = cbq_pkg::DLY_W;
    localparam int RND_W = cbq_pkg::RND_W;
    localparam int PRW   = ACC_W - 24;
    localparam logic [SW-1:0] SEC_LAST = SW'(SECTIONS - 1);

    cbq_pkg::state_t state_reg, state_next;

    // Input field split
    logic signed [15:0] in_sample;
    logic [2:0]         in_sec;
    logic [2:0]         in_slot;
    logic signed [17:0] in_coef;
    assign in_sample = s_tdata[15:0];
    assign in_sec    = s_tdata[18:16];
    assign in_slot   = s_tdata[21:19];
    assign in_coef   = s_tdata[39:22];

    // Coefficient memory with per-entry valid bits
    logic signed [17:0] coef_mem [DEPTH];
    logic [DEPTH-1:0]   coef_vld_reg;
    logic signed [17:0] coef_rd_reg;
    logic               coef_rd_vld_reg;

    // Section delays
    logic signed [DLY_W-1:0] w1_reg [SECTIONS];
    logic signed [DLY_W-1:0] w2_reg [SECTIONS];

    // Datapath registers
    logic [SW-1:0]           sec_reg;
    logic [2:0]              prod_reg;
    logic [cbq_pkg::CNT_W-1:0] cnt_reg;
    logic [cbq_pkg::CNT_W-1:0] last_reg;
    logic                    sgn_mode_reg;
    logic                    neg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] mcand_reg;
    logic [17:0]             mult_sh_reg;
    logic signed [DLY_W-1:0] x_reg;
    logic signed [DLY_W-1:0] cw1_reg;
    logic signed [DLY_W-1:0] cw2_reg;
    logic signed [DLY_W-1:0] w_reg;
    logic                    clip_reg;
    logic [15:0]             gain_reg;
    logic                    out_vld_reg;
    logic [15:0]             out_data_reg;
    logic                    out_clip_reg;

    logic in_acc, coef_wr, out_free, mul_done;
    logic [AW-1:0] wr_addr, rd_addr;

    assign in_acc   = s_tvalid && s_tready;
    assign coef_wr  = in_acc && (s_tuser == cbq_pkg::KIND_COEF)
                      && ({2'b00, in_sec} < 5'(SECTIONS))
                      && (in_slot < 3'(cbq_pkg::COEFS_PER));
    assign wr_addr  = AW'({in_sec, 2'b00}) + AW'(in_sec) + AW'(in_slot);
    assign rd_addr  = AW'({sec_reg, 2'b00}) + AW'(sec_reg)
                      + AW'(cbq_pkg::slot_of(prod_reg));
    assign out_free = !out_vld_reg || m_tready;
    assign mul_done = (cnt_reg == last_reg);

    // Operand for the current product step
    logic signed [DLY_W-1:0] operand;
    always_comb
    begin
        case (prod_reg)
            cbq_pkg::PROD_A1: operand = cw1_reg;
            cbq_pkg::PROD_A2: operand = cw2_reg;
            cbq_pkg::PROD_B0: operand = w_reg;
            cbq_pkg::PROD_B1: operand = cw1_reg;
            cbq_pkg::PROD_B2: operand = cw2_reg;
            default:          operand = cw1_reg;
        endcase
    end

    // Round half up to Q8.24 and saturate to 32 bits
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [RND_W-1:0] rnd;
    logic                    rnd_ovf;
    logic signed [DLY_W-1:0] rnd_sat;
    always_comb
    begin
        acc_rnd = acc_reg + ACC_W'(32768);
        rnd     = acc_rnd[ACC_W-1:16];
        rnd_ovf = (rnd[RND_W-1:DLY_W-1] != '0) && (rnd[RND_W-1:DLY_W-1] != '1);
        if (!rnd_ovf)
            rnd_sat = rnd[DLY_W-1:0];
        else if (rnd[RND_W-1])
            rnd_sat = {1'b1, {(DLY_W-1){1'b0}}};
        else
            rnd_sat = {1'b0, {(DLY_W-1){1'b1}}};
    end

    // Output: truncate toward zero by 2^24, saturate to int16
    logic signed [ACC_W-1:0] acc_tz;
    logic signed [PRW-1:0]   pr;
    logic                    pr_ovf;
    logic [15:0]             pr_sat;
    always_comb
    begin
        acc_tz = acc_reg[ACC_W-1] ? (acc_reg + ACC_W'(24'hFFFFFF)) : acc_reg;
        pr     = acc_tz[ACC_W-1:24];
        pr_ovf = (pr[PRW-1:15] != '0) && (pr[PRW-1:15] != '1);
        if (!pr_ovf)
            pr_sat = pr[15:0];
        else if (pr[PRW-1])
            pr_sat = 16'h8000;
        else
            pr_sat = 16'h7FFF;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbq_pkg::ST_IDLE:
                if (in_acc && s_tuser == cbq_pkg::KIND_SAMPLE)
                    state_next = cbq_pkg::ST_SEC_START;
            cbq_pkg::ST_SEC_START: state_next = cbq_pkg::ST_FETCH;
            cbq_pkg::ST_FETCH:     state_next = cbq_pkg::ST_LOAD;
            cbq_pkg::ST_LOAD:      state_next = cbq_pkg::ST_MUL;
            cbq_pkg::ST_MUL:
                if (mul_done)
                begin
                    if (prod_reg == cbq_pkg::PROD_A2 || prod_reg == cbq_pkg::PROD_B2)
                        state_next = cbq_pkg::ST_ROUND;
                    else
                        state_next = cbq_pkg::ST_FETCH;
                end
            cbq_pkg::ST_ROUND:
                if (prod_reg == cbq_pkg::PROD_A2)
                    state_next = cbq_pkg::ST_FETCH;
                else if (sec_reg == SEC_LAST)
                    state_next = cbq_pkg::ST_GAIN_MUL;
                else
                    state_next = cbq_pkg::ST_SEC_START;
            cbq_pkg::ST_GAIN_MUL:
                if (mul_done)
                    state_next = cbq_pkg::ST_OUT;
            cbq_pkg::ST_OUT:
                if (out_free)
                    state_next = cbq_pkg::ST_IDLE;
            default: state_next = cbq_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_tready  = (state_reg == cbq_pkg::ST_IDLE);
        cfg_ready = 1'b1;
        m_tvalid  = out_vld_reg;
        m_tdata   = out_data_reg;
        m_tuser   = out_clip_reg;
    end

    // Coefficient memory write and registered read
    always_ff @(posedge clk)
    begin
        if (coef_wr)
            coef_mem[wr_addr] <= in_coef;
        if (state_reg == cbq_pkg::ST_FETCH)
            coef_rd_reg <= coef_mem[rd_addr];
    end

    // Control, delays and sequencer datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cbq_pkg::ST_IDLE;
            coef_vld_reg    <= '0;
            coef_rd_vld_reg <= 1'b0;
            gain_reg        <= cbq_pkg::GAIN_RESET;
            out_vld_reg     <= 1'b0;
            for (int i = 0; i < SECTIONS; i++)
            begin
                w1_reg[i] <= '0;
                w2_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                gain_reg <= cfg_data;
            if (coef_wr)
                coef_vld_reg[wr_addr] <= 1'b1;

            // Output beat: load a new result or drop the taken one
            if (state_reg == cbq_pkg::ST_OUT && out_free)
                out_vld_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                out_vld_reg <= 1'b0;

            case (state_reg)
                cbq_pkg::ST_IDLE:
                begin
                    sec_reg  <= '0;
                    clip_reg <= 1'b0;
                    x_reg    <= DLY_W'(in_sample) <<< 9;
                end
                cbq_pkg::ST_SEC_START:
                begin
                    cw1_reg  <= w1_reg[sec_reg];
                    cw2_reg  <= w2_reg[sec_reg];
                    acc_reg  <= ACC_W'(x_reg) <<< 16;
                    prod_reg <= cbq_pkg::PROD_A1;
                end
                cbq_pkg::ST_FETCH:
                    coef_rd_vld_reg <= coef_vld_reg[rd_addr];
                cbq_pkg::ST_LOAD:
                begin
                    mult_sh_reg  <= coef_rd_vld_reg ? coef_rd_reg : '0;
                    mcand_reg    <= ACC_W'(operand);
                    cnt_reg      <= '0;
                    last_reg     <= cbq_pkg::CNT_W'(cbq_pkg::COEF_W - 1);
                    sgn_mode_reg <= 1'b1;
                    neg_reg      <= (prod_reg == cbq_pkg::PROD_A1)
                                    || (prod_reg == cbq_pkg::PROD_A2);
                end
                cbq_pkg::ST_MUL, cbq_pkg::ST_GAIN_MUL:
                begin
                    // one multiplier bit per cycle
                    if (mult_sh_reg[0])
                    begin
                        if (neg_reg ^ (sgn_mode_reg && mul_done))
                            acc_reg <= acc_reg - mcand_reg;
                        else
                            acc_reg <= acc_reg + mcand_reg;
                    end
                    mult_sh_reg <= mult_sh_reg >> 1;
                    mcand_reg   <= mcand_reg <<< 1;
                    cnt_reg     <= cnt_reg + 1'b1;
                    if (state_reg == cbq_pkg::ST_MUL && mul_done
                        && prod_reg != cbq_pkg::PROD_A2 && prod_reg != cbq_pkg::PROD_B2)
                        prod_reg <= prod_reg + 3'd1;
                end
                cbq_pkg::ST_ROUND:
                begin
                    if (rnd_ovf)
                        clip_reg <= 1'b1;
                    if (prod_reg == cbq_pkg::PROD_A2)
                    begin
                        w_reg    <= rnd_sat;
                        acc_reg  <= '0;
                        prod_reg <= cbq_pkg::PROD_B0;
                    end
                    else
                    begin
                        w2_reg[sec_reg] <= cw1_reg;
                        w1_reg[sec_reg] <= w_reg;
                        x_reg           <= rnd_sat;
                        sec_reg         <= sec_reg + 1'b1;
                        // set up the gain product
                        acc_reg      <= '0;
                        mcand_reg    <= ACC_W'(rnd_sat);
                        mult_sh_reg  <= {2'b00, gain_reg};
                        cnt_reg      <= '0;
                        last_reg     <= cbq_pkg::CNT_W'(cbq_pkg::GAIN_W - 1);
                        sgn_mode_reg <= 1'b0;
                        neg_reg      <= 1'b0;
                    end
                end
                cbq_pkg::ST_OUT:
                    if (out_free)
                    begin
                        out_data_reg <= pr_sat;
                        out_clip_reg <= clip_reg || pr_ovf;
                    end
                default: ;
            endcase
        end
    end

endmodule

// ----- test/cascaded_biquad_iir_filter_test.sv -----
// Testbench for the cascaded biquad filter: directed table plus random beats vs a predictor.
`timescale 1ns / 1ps

module cascaded_biquad_iir_filter_test;

    localparam int NSEC = 8;
    localparam int RANDOM_ITEMS = 600;
    localparam int SETTLE_CYCLES = 2000;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample;
        logic [2:0]  section;
        logic [2:0]  slot;
        logic [17:0] value;
    } item_t;

    typedef struct packed {
        logic [15:0] sample_out;
        logic        clipped;
        logic        known;      // typed-in row value present
    } filt_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Predictor state
    logic signed [17:0] coef_mem [NSEC*cbq_pkg::COEFS_PER];
    logic signed [31:0] dly_mem [NSEC*2];
    logic [15:0]        gain_reg;

    filt_result_t expected_q[$];
    int errors = 0;
    int samples_seen = 0;
    int coef_writes = 0;
    int clips_seen = 0;
    int gains_used = 0;

    cascaded_biquad_iir_filter #(.SECTIONS(NSEC)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Round Q.40 sum to Q8.24 (half up), saturate to 32 bits
    function automatic logic signed [31:0] round_q24(input logic signed [63:0] acc,
                                                     inout logic clip);
        logic signed [63:0] r;
        r = (acc + 64'sd32768) >>> 16;
        if (r > 64'sd2147483647)
        begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (r < -64'sd2147483648)
        begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return r[31:0];
    endfunction

    // Apply one item to the predictor; returns 1 if it yields a result
    function automatic bit biquad_predict(input item_t it, output filt_result_t res);
        logic signed [63:0] x, y, acc, w1, w2, w, o, prod;
        logic               clip;
        int                 b;
        res = '0;
        if (it.kind == cbq_pkg::KIND_COEF)
        begin
            if (it.section < NSEC && it.slot < cbq_pkg::COEFS_PER)
                coef_mem[it.section*cbq_pkg::COEFS_PER + it.slot] = it.value;
            return 1'b0;
        end
        clip = 1'b0;
        y = 0;
        x = 64'(signed'(it.sample)) <<< 9;
        for (int s = 0; s < NSEC; s++)
        begin
            b = s * cbq_pkg::COEFS_PER;
            w1 = dly_mem[s*2];
            w2 = dly_mem[s*2+1];
            acc = (x <<< 16) - 64'(coef_mem[b+cbq_pkg::SLOT_A1]) * w1
                - 64'(coef_mem[b+cbq_pkg::SLOT_A2]) * w2;
            w = round_q24(acc, clip);
            acc = 64'(coef_mem[b+cbq_pkg::SLOT_B0]) * w
                + 64'(coef_mem[b+cbq_pkg::SLOT_B1]) * w1
                + 64'(coef_mem[b+cbq_pkg::SLOT_B2]) * w2;
            y = round_q24(acc, clip);
            dly_mem[s*2+1] = w1[31:0];
            dly_mem[s*2] = w[31:0];
            x = y;
        end
        prod = y * 64'(gain_reg);
        o = (prod < 0) ? -((-prod) >>> 24) : (prod >>> 24);
        if (o > 64'sd32767)
        begin
            o = 32767;
            clip = 1'b1;
        end
        if (o < -64'sd32768)
        begin
            o = -32768;
            clip = 1'b1;
        end
        res.sample_out = o[15:0];
        res.clipped = clip;
        return 1'b1;
    endfunction

    function automatic item_t coef_item(input int sec, input int slot, input int val);
        item_t it;
        it = '0;
        it.kind = cbq_pkg::KIND_COEF;
        it.section = sec[2:0];
        it.slot = slot[2:0];
        it.value = val[17:0];
        return it;
    endfunction

    function automatic item_t sample_item(input int val);
        item_t it;
        it = '0;
        it.kind = cbq_pkg::KIND_SAMPLE;
        it.sample = val[15:0];
        return it;
    endfunction

    // Send one beat, predicting on acceptance; optional typed-in expectation
    task automatic send_beat(input item_t it, input bit has_known,
                             input logic [15:0] k_out, input logic k_clip);
        filt_result_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.value, it.slot, it.section, it.sample};
        do
            @(posedge clk);
        while (!s_tready);
        if (biquad_predict(it, res))
        begin
            if (has_known && (res.sample_out !== k_out || res.clipped !== k_clip))
            begin
                $display("%0t: table row disagrees: table %h/%b predictor %h/%b",
                         $time, k_out, k_clip, res.sample_out, res.clipped);
                errors++;
            end
            expected_q.push_back(res);
            samples_seen++;
        end
        else
            coef_writes++;
    endtask

    task automatic sender_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
    endtask

    // Wait for the block to drain, then write the gain
    task automatic write_gain(input logic [15:0] g);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gain_reg = g;
        gains_used++;
    endtask

    // Random coefficient, mostly gentle so deep states stay unclipped
    function automatic int rand_coef(input int slot);
        case ($urandom_range(0, 9))
            0: return -131072;
            1: return 131071;
            2: return $urandom_range(0, 262143) - 131072;
            default:
                if (slot >= cbq_pkg::SLOT_A1)
                    return $urandom_range(0, 60000) - 30000;
                else
                    return $urandom_range(0, 40000) - 20000;
        endcase
    endfunction

    // Result checking
    always @(posedge clk)
    begin
        filt_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected beat, actual %h/%b", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tdata !== e.sample_out)
                begin
                    $display("%0t: sample_out expected %h actual %h", $time,
                             e.sample_out, m_tdata);
                    errors++;
                end
                if (m_tuser !== e.clipped)
                begin
                    $display("%0t: clipped expected %b actual %b", $time,
                             e.clipped, m_tuser);
                    errors++;
                end
                if (e.clipped)
                    clips_seen++;
            end
        end
    end

    // Receiver stall pattern: runs of ready and stall, sometimes long
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 40) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(50, 1500)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: m_tready <= 1'b0;
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Timeout
    initial
    begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        item_t tbl_item [$];
        bit    tbl_known [$];
        logic [15:0] tbl_out [$];
        logic  tbl_clip [$];
        item_t it;
        int    burst;
        int    sec;
        int    slot;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        for (int i = 0; i < NSEC*cbq_pkg::COEFS_PER; i++) coef_mem[i] = '0;
        for (int i = 0; i < NSEC*2; i++) dly_mem[i] = '0;
        gain_reg = cbq_pkg::GAIN_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: zero coefficients after reset give zero output
        tbl_item.push_back(sample_item(32767));  tbl_known.push_back(1);
        tbl_out.push_back(16'h0000); tbl_clip.push_back(1'b0);
        tbl_item.push_back(sample_item(-32768)); tbl_known.push_back(1);
        tbl_out.push_back(16'h0000); tbl_clip.push_back(1'b0);
        // Pass-through b0 = 1.0 in every section
        for (int s = 0; s < NSEC; s++)
        begin
            tbl_item.push_back(coef_item(s, cbq_pkg::SLOT_B0, 65536));
            tbl_known.push_back(0); tbl_out.push_back('0); tbl_clip.push_back(0);
        end
        // Full scale of either sign: 1.0 * 60000 overflows the output; zero stays zero
        tbl_item.push_back(sample_item(32767));  tbl_known.push_back(1);
        tbl_out.push_back(16'h7fff); tbl_clip.push_back(1'b1);
        tbl_item.push_back(sample_item(-32768)); tbl_known.push_back(1);
        tbl_out.push_back(16'h8000); tbl_clip.push_back(1'b1);
        tbl_item.push_back(sample_item(0));      tbl_known.push_back(1);
        tbl_out.push_back(16'h0000); tbl_clip.push_back(1'b0);
        // Ignored writes: slot above a2, slot 7
        tbl_item.push_back(coef_item(0, 5, 131071));
        tbl_known.push_back(0); tbl_out.push_back('0); tbl_clip.push_back(0);
        tbl_item.push_back(coef_item(7, 7, -131072));
        tbl_known.push_back(0); tbl_out.push_back('0); tbl_clip.push_back(0);
        // Extreme coefficients in the b1, b2, a1 and a2 slots of one section
        tbl_item.push_back(coef_item(3, cbq_pkg::SLOT_B1, 131071));
        tbl_known.push_back(0); tbl_out.push_back('0); tbl_clip.push_back(0);
        tbl_item.push_back(coef_item(3, cbq_pkg::SLOT_B2, -131072));
        tbl_known.push_back(0); tbl_out.push_back('0); tbl_clip.push_back(0);
        tbl_item.push_back(coef_item(3, cbq_pkg::SLOT_A1, -131072));
        tbl_known.push_back(0); tbl_out.push_back('0); tbl_clip.push_back(0);
        tbl_item.push_back(coef_item(3, cbq_pkg::SLOT_A2, 131071));
        tbl_known.push_back(0); tbl_out.push_back('0); tbl_clip.push_back(0);
        for (int i = 0; i < 5; i++)
        begin
            tbl_item.push_back(sample_item((i % 2) ? -32768 : 32767));
            tbl_known.push_back(0); tbl_out.push_back('0); tbl_clip.push_back(0);
        end

        foreach (tbl_item[i])
            send_beat(tbl_item[i], tbl_known[i], tbl_out[i], tbl_clip[i]);

        // Gain extremes on a clean cascade
        write_gain(16'd0);
        send_beat(coef_item(3, cbq_pkg::SLOT_B1, 0), 0, '0, 0);
        send_beat(coef_item(3, cbq_pkg::SLOT_B2, 0), 0, '0, 0);
        send_beat(coef_item(3, cbq_pkg::SLOT_A1, 0), 0, '0, 0);
        send_beat(coef_item(3, cbq_pkg::SLOT_A2, 0), 0, '0, 0);
        send_beat(sample_item(12345), 0, '0, 0);
        write_gain(16'hffff);
        send_beat(sample_item(-1), 0, '0, 0);
        send_beat(sample_item(1), 0, '0, 0);

        // Random part in phases with different gains
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_gain(16'd1);
                1: write_gain(16'($urandom_range(0, 65535)));
                2: write_gain(cbq_pkg::GAIN_RESET);
                default: write_gain(16'($urandom_range(100, 4000)));
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; )
            begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst; k++)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        // Coefficient write, sometimes out of range
                        sec = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                          : $urandom_range(0, NSEC-1);
                        slot = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                           : $urandom_range(0, 4);
                        it = coef_item(sec, slot, rand_coef(slot));
                    end
                    else
                    begin
                        case ($urandom_range(0, 7))
                            0: it = sample_item(32767);
                            1: it = sample_item(-32768);
                            default: it = sample_item($urandom_range(0, 65535));
                        endcase
                    end
                    send_beat(it, 0, '0, 0);
                    n++;
                end
                if ($urandom_range(0, 2) != 0)
                    sender_gap();
            end
            // Hold off until every result is back
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (expected_q.size() != 0) @(posedge clk);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Filtered %0d samples, %0d coefficient writes, %0d gain settings,",
                 samples_seen, coef_writes, gains_used);
        $display("of which %0d results carried the clip flag.", clips_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
